// ===== hw/rtl/snappy_pkg.sv =====
// Shared constants and types of the raw-block decompressor.
package snappy_pkg;
  localparam int unsigned WindowBytes = 65536;
  localparam int unsigned WinAw = $clog2(WindowBytes);

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_HDR  = 3'd1;
  localparam logic [2:0] ST_OVER_CAP = 3'd2;
  localparam logic [2:0] ST_TRUNC    = 3'd3;
  localparam logic [2:0] ST_BAD_OFS  = 3'd4;
  localparam logic [2:0] ST_OVERRUN  = 3'd5;
  localparam logic [2:0] ST_LEN_MIS  = 3'd6;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_TAG    = 3'd1,
    PH_LITLEN = 3'd2,
    PH_LITDAT = 3'd3,
    PH_OFFSET = 3'd4
  } phase_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PARSE = 6'b000010,
    S_CHECK = 6'b000100,
    S_RDREQ = 6'b001000,
    S_EMIT  = 6'b010000,
    S_FINAL = 6'b100000
  } seq_t;
endpackage

// ===== hw/rtl/snappy_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
module snappy_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/snappy_raw_decompressor_core.sv =====
// Top level of the raw-block decompressor: parser, sequencer and history.
// One compressed byte is taken per item; the block then stays busy until every
// result it causes has been handed on. Each byte is parsed and then finished; header,
// literal length and offset bytes pass a check between the two. Every copied byte is a
// read of the history memory followed by its output. The history window holds the
// last 65536 output bytes; it needs no clearing since only bytes written in the
// current stream are read back.
module snappy_raw_decompressor_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // in_byte
  input  logic        s_tlast,   // in_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // out_byte
  output logic        m_tlast,   // run_last
  output logic [4:0]  m_tuser,   // byte_valid, stream_done, status[2:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);
  localparam int unsigned Aw = snappy_pkg::WinAw;

  snappy_pkg::seq_t   seq;
  snappy_pkg::phase_t phase;
  logic [31:0] out_capacity;
  logic [31:0] expected_length;
  logic [31:0] written_count;
  logic [34:0] acc;
  logic [2:0]  fidx;
  logic [7:0]  saved_tag;
  logic [32:0] lit_rem;
  logic [2:0]  err;
  logic [7:0]  in_b;
  logic        in_l;
  logic [6:0]  copy_rem;
  logic [Aw-1:0] copy_ofs;
  logic        emitted;

  // Output register.
  logic        o_valid;
  logic [7:0]  o_byte;
  logic        o_bv, o_last, o_done;
  logic [2:0]  o_status;

  // History memory.
  logic          h_we;
  logic [Aw-1:0] h_waddr, h_raddr;
  logic [7:0]    h_wdata, h_rdata;

  // The last data byte of a stream is held back until its status is known.
  logic hold_last;
  assign hold_last = (seq == snappy_pkg::S_FINAL) && in_l && emitted;

  snappy_ram #(.Width(8), .Depth(snappy_pkg::WindowBytes)) u_hist (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata)
  );

  assign s_tready  = (seq == snappy_pkg::S_IDLE) && !o_valid;
  assign cfg_ready = 1'b1;
  assign m_tvalid  = o_valid && !hold_last;
  assign m_tdata   = o_byte;
  assign m_tlast   = o_last;
  assign m_tuser   = {o_status, o_done, o_bv};

  assign h_waddr = written_count[Aw-1:0];
  assign h_raddr = written_count[Aw-1:0] - copy_ofs;

  logic [32:0] room;
  assign room = {1'b0, expected_length} - {1'b0, written_count};

  // Copy parameters from the saved tag and accumulated offset.
  logic [32:0] c_ofs;
  logic [6:0]  c_len;
  always_comb begin
    if (saved_tag[1:0] == 2'd1) begin
      c_ofs = {22'd0, saved_tag[7:5], acc[7:0]};
      c_len = 7'd4 + {4'd0, saved_tag[4:2]};
    end else begin
      c_ofs = {1'b0, acc[31:0]};
      c_len = {1'b0, saved_tag[7:2]} + 7'd1;
    end
  end

  logic [2:0] need;
  always_comb begin
    case (saved_tag[1:0])
      2'd1:    need = 3'd1;
      2'd2:    need = 3'd2;
      default: need = 3'd4;
    endcase
  end

  logic out_free;
  assign out_free = !o_valid || (m_tready && !hold_last);

  // Each output byte is written into history at the edge where it is emitted.
  assign h_we = out_free && ((seq == snappy_pkg::S_EMIT) ||
                ((seq == snappy_pkg::S_PARSE) && (err == snappy_pkg::ST_OK) &&
                 (phase == snappy_pkg::PH_LITDAT)));
  assign h_wdata = (seq == snappy_pkg::S_EMIT) ? h_rdata : in_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= snappy_pkg::S_IDLE;
      phase <= snappy_pkg::PH_HEADER;
      out_capacity <= 32'hFFFF_FFFF;
      expected_length <= '0;
      written_count <= '0;
      acc <= '0;
      fidx <= '0;
      saved_tag <= '0;
      lit_rem <= '0;
      err <= '0;
      o_valid <= 1'b0;
      emitted <= 1'b0;
    end else begin
      if (out_free && !(seq == snappy_pkg::S_EMIT)) begin
        o_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        out_capacity <= cfg_data;
      end
      case (seq)
        snappy_pkg::S_IDLE: begin
          emitted <= 1'b0;
          if (s_tvalid && s_tready) begin
            in_b <= s_tdata;
            in_l <= s_tlast;
            seq  <= snappy_pkg::S_PARSE;
          end
        end
        snappy_pkg::S_PARSE: begin
          seq <= snappy_pkg::S_FINAL;
          if (err == snappy_pkg::ST_OK) begin
            case (phase)
              snappy_pkg::PH_HEADER: begin
                acc  <= acc | ({28'd0, in_b[6:0]} << (7 * fidx));
                fidx <= fidx + 3'd1;
                seq  <= snappy_pkg::S_CHECK;
              end
              snappy_pkg::PH_TAG: begin
                saved_tag <= in_b;
                acc  <= '0;
                fidx <= '0;
                if (in_b[1:0] == 2'd0) begin
                  if (in_b[7:2] >= 6'd60) begin
                    phase <= snappy_pkg::PH_LITLEN;
                  end else if ({27'd0, in_b[7:2]} + 33'd1 > room) begin
                    err <= snappy_pkg::ST_OVERRUN;
                  end else begin
                    lit_rem <= {27'd0, in_b[7:2]} + 33'd1;
                    phase   <= snappy_pkg::PH_LITDAT;
                  end
                end else begin
                  phase <= snappy_pkg::PH_OFFSET;
                end
              end
              snappy_pkg::PH_LITLEN, snappy_pkg::PH_OFFSET: begin
                acc  <= acc | ({27'd0, in_b} << (8 * fidx));
                fidx <= fidx + 3'd1;
                seq  <= snappy_pkg::S_CHECK;
              end
              snappy_pkg::PH_LITDAT: begin
                if (out_free) begin
                  o_valid <= 1'b1; o_byte <= in_b; o_bv <= 1'b1;
                  o_last <= !in_l; o_done <= 1'b0; o_status <= snappy_pkg::ST_OK;
                  written_count <= written_count + 32'd1;
                  emitted <= 1'b1;
                  lit_rem <= lit_rem - 33'd1;
                  if (lit_rem == 33'd1) begin
                    phase <= snappy_pkg::PH_TAG;
                  end
                end else begin
                  seq <= snappy_pkg::S_PARSE;
                end
              end
              default: phase <= snappy_pkg::PH_HEADER;
            endcase
          end
        end
        snappy_pkg::S_CHECK: begin
          seq <= snappy_pkg::S_FINAL;
          case (phase)
            snappy_pkg::PH_HEADER: begin
              if (!in_b[7]) begin
                if (acc[34:32] != 3'd0) begin
                  err <= snappy_pkg::ST_BAD_HDR;
                end else if (acc[31:0] > out_capacity) begin
                  err <= snappy_pkg::ST_OVER_CAP;
                end else begin
                  expected_length <= acc[31:0];
                  written_count   <= '0;
                  phase <= snappy_pkg::PH_TAG;
                end
                acc  <= '0;
                fidx <= '0;
              end else if (fidx >= 3'd5) begin
                err <= snappy_pkg::ST_BAD_HDR;
              end
            end
            snappy_pkg::PH_LITLEN: begin
              if ({3'd0, fidx} >= saved_tag[7:2] - 6'd59) begin
                if ({1'b0, acc[31:0]} + 33'd1 > room) begin
                  err <= snappy_pkg::ST_OVERRUN;
                end else begin
                  lit_rem <= {1'b0, acc[31:0]} + 33'd1;
                  phase   <= snappy_pkg::PH_LITDAT;
                end
              end
            end
            default: begin
              if (fidx >= need) begin
                phase <= snappy_pkg::PH_TAG;
                if (c_ofs == 33'd0 || c_ofs > {1'b0, written_count} ||
                    c_ofs > 33'(snappy_pkg::WindowBytes)) begin
                  err <= snappy_pkg::ST_BAD_OFS;
                end else if ({26'd0, c_len} > room) begin
                  err <= snappy_pkg::ST_OVERRUN;
                end else begin
                  copy_ofs <= c_ofs[Aw-1:0];
                  copy_rem <= c_len;
                  seq      <= snappy_pkg::S_RDREQ;
                end
              end
            end
          endcase
        end
        snappy_pkg::S_RDREQ: begin
          // Read address is presented this cycle; data is ready next cycle.
          seq <= snappy_pkg::S_EMIT;
        end
        snappy_pkg::S_EMIT: begin
          if (out_free) begin
            o_valid <= 1'b1; o_byte <= h_rdata; o_bv <= 1'b1;
            o_done <= 1'b0; o_status <= snappy_pkg::ST_OK;
            o_last <= (copy_rem == 7'd1) && !in_l;
            written_count <= written_count + 32'd1;
            emitted  <= 1'b1;
            copy_rem <= copy_rem - 7'd1;
            seq <= (copy_rem == 7'd1) ? snappy_pkg::S_FINAL : snappy_pkg::S_RDREQ;
          end
        end
        snappy_pkg::S_FINAL: begin
          if (!in_l) begin
            seq <= snappy_pkg::S_IDLE;
          end else if (emitted) begin
            // Turn the held last data byte into the stream's final result.
            if (o_valid) begin
              o_last <= 1'b1; o_done <= 1'b1;
              o_status <= (err != snappy_pkg::ST_OK) ? err :
                          (phase != snappy_pkg::PH_TAG) ? snappy_pkg::ST_TRUNC :
                          (written_count != expected_length) ? snappy_pkg::ST_LEN_MIS :
                          snappy_pkg::ST_OK;
              o_valid <= 1'b1;
              seq <= snappy_pkg::S_IDLE;
              err <= '0; phase <= snappy_pkg::PH_HEADER; expected_length <= '0;
              written_count <= '0; acc <= '0; fidx <= '0; saved_tag <= '0;
              lit_rem <= '0;
            end
          end else if (out_free) begin
            o_valid <= 1'b1; o_byte <= 8'd0; o_bv <= 1'b0;
            o_last <= 1'b1; o_done <= 1'b1;
            o_status <= (err != snappy_pkg::ST_OK) ? err :
                        (phase == snappy_pkg::PH_HEADER) ? snappy_pkg::ST_BAD_HDR :
                        (phase != snappy_pkg::PH_TAG) ? snappy_pkg::ST_TRUNC :
                        (written_count != expected_length) ? snappy_pkg::ST_LEN_MIS :
                        snappy_pkg::ST_OK;
            seq <= snappy_pkg::S_IDLE;
            err <= '0; phase <= snappy_pkg::PH_HEADER; expected_length <= '0;
            written_count <= '0; acc <= '0; fidx <= '0; saved_tag <= '0;
            lit_rem <= '0;
          end
        end
        default: seq <= snappy_pkg::S_IDLE;
      endcase
    end
  end

  // A copy only runs with a nonzero length.
  a_copy_len: assert property (@(posedge clk) disable iff (rst)
    seq == snappy_pkg::S_EMIT |-> copy_rem != 7'd0) else $error("copy length zero");
  // Input is never taken while a result waits.
  a_no_take: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !o_valid) else $error("ready with result pending");
  // A finished stream leaves the parser in its header phase.
  a_done_reset: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1] && $rose(m_tvalid)) |-> phase == snappy_pkg::PH_HEADER)
    else $error("stream state not cleared");
  // Bytes are written into history only inside a stream with a header.
  a_hist_in_stream: assert property (@(posedge clk) disable iff (rst)
    h_we |-> phase != snappy_pkg::PH_HEADER || $past(in_l)) else $error("history write");
endmodule

// ===== verif/snappy_checker.sv =====
// Checker that predicts and compares the decompressed output of the core.
`timescale 1ns / 100ps

module snappy_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,
  input  logic        m_tlast,
  input  logic [4:0]  m_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_data,
  output int          pending,
  output int          fail_count
);

  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       run_last;
    logic       stream_done;
    logic [2:0] status;
  } out_item_t;

  out_item_t          expected_bytes[$];
  out_item_t          batch[$];
  logic [7:0]         history [0:snappy_pkg::WindowBytes-1];
  logic [31:0]        capacity;
  snappy_pkg::phase_t phase;
  longint unsigned    decl_len, written, accum, lit_left;
  int unsigned        field_idx;
  logic [7:0]         tag;
  logic [2:0]         err;

  assign pending = expected_bytes.size();

  task automatic clear_stream();
    phase = snappy_pkg::PH_HEADER;
    decl_len = 0;
    written = 0;
    accum = 0;
    field_idx = 0;
    tag = 0;
    lit_left = 0;
    err = snappy_pkg::ST_OK;
  endtask

  task automatic push_byte(input logic [7:0] b);
    out_item_t r;
    r = '0;
    r.data = b;
    r.byte_valid = 1'b1;
    batch.push_back(r);
    history[written % snappy_pkg::WindowBytes] = b;
    written++;
  endtask

  task automatic open_literal(input longint unsigned len);
    if (len > decl_len - written) err = snappy_pkg::ST_OVERRUN;
    else begin
      lit_left = len;
      phase = snappy_pkg::PH_LITDAT;
    end
  endtask

  task automatic run_copy();
    longint unsigned ofs, len;
    if (tag[1:0] == 2'd1) begin
      ofs = (longint'(tag[7:5]) << 8) | accum;
      len = 4 + tag[4:2];
    end else begin
      ofs = accum;
      len = tag[7:2] + 1;
    end
    phase = snappy_pkg::PH_TAG;
    if (ofs == 0 || ofs > written || ofs > snappy_pkg::WindowBytes)
      err = snappy_pkg::ST_BAD_OFS;
    else if (len > decl_len - written) err = snappy_pkg::ST_OVERRUN;
    else
      for (longint unsigned i = 0; i < len; i++)
        push_byte(history[(written - ofs) % snappy_pkg::WindowBytes]);
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic last);
    out_item_t r;
    int unsigned need;
    batch.delete();
    if (err == snappy_pkg::ST_OK) begin
      case (phase)
        snappy_pkg::PH_HEADER: begin
          accum |= longint'(b[6:0]) << (7 * field_idx);
          field_idx++;
          if (!b[7]) begin
            if (accum > 64'hFFFF_FFFF) err = snappy_pkg::ST_BAD_HDR;
            else if (accum > capacity) err = snappy_pkg::ST_OVER_CAP;
            else begin
              decl_len = accum;
              written = 0;
              phase = snappy_pkg::PH_TAG;
            end
            accum = 0;
            field_idx = 0;
          end else if (field_idx >= 5) err = snappy_pkg::ST_BAD_HDR;
        end
        snappy_pkg::PH_TAG: begin
          tag = b;
          accum = 0;
          field_idx = 0;
          if (b[1:0] == 2'd0) begin
            if (b[7:2] >= 60) phase = snappy_pkg::PH_LITLEN;
            else open_literal(b[7:2] + 1);
          end else phase = snappy_pkg::PH_OFFSET;
        end
        snappy_pkg::PH_LITLEN: begin
          accum |= longint'(b) << (8 * field_idx);
          field_idx++;
          if (field_idx >= tag[7:2] - 59) open_literal(accum + 1);
        end
        snappy_pkg::PH_LITDAT: begin
          push_byte(b);
          lit_left--;
          if (lit_left == 0) phase = snappy_pkg::PH_TAG;
        end
        default: begin
          need = (tag[1:0] == 2'd1) ? 1 : (tag[1:0] == 2'd2) ? 2 : 4;
          accum |= longint'(b) << (8 * field_idx);
          field_idx++;
          if (field_idx >= need) run_copy();
        end
      endcase
    end
    if (last) begin
      if (err == snappy_pkg::ST_OK) begin
        if (phase == snappy_pkg::PH_HEADER) err = snappy_pkg::ST_BAD_HDR;
        else if (phase != snappy_pkg::PH_TAG) err = snappy_pkg::ST_TRUNC;
        else if (written != decl_len) err = snappy_pkg::ST_LEN_MIS;
      end
      if (batch.size() == 0) begin
        r = '0;
        batch.push_back(r);
      end
      batch[$].stream_done = 1'b1;
      batch[$].status = err;
      clear_stream();
    end
    if (batch.size() > 0) batch[$].run_last = 1'b1;
    foreach (batch[i]) expected_bytes.push_back(batch[i]);
  endtask

  task automatic compare_result();
    out_item_t e;
    if (expected_bytes.size() == 0) begin
      $error("output item with nothing expected: data %0h user %0h", m_tdata, m_tuser);
      fail_count++;
      return;
    end
    e = expected_bytes.pop_front();
    if (m_tuser[0] !== e.byte_valid) begin
      $error("byte_valid: expected %0d actual %0d", e.byte_valid, m_tuser[0]);
      fail_count++;
    end
    if (m_tdata !== e.data) begin
      $error("out_byte: expected %0h actual %0h", e.data, m_tdata);
      fail_count++;
    end
    if (m_tlast !== e.run_last) begin
      $error("run_last: expected %0d actual %0d", e.run_last, m_tlast);
      fail_count++;
    end
    if (m_tuser[1] !== e.stream_done) begin
      $error("stream_done: expected %0d actual %0d", e.stream_done, m_tuser[1]);
      fail_count++;
    end
    if (m_tuser[4:2] !== e.status) begin
      $error("status: expected %0d actual %0d", e.status, m_tuser[4:2]);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    capacity = 32'hFFFF_FFFF;
    clear_stream();
  end

  always @(posedge clk) begin
    if (rst) begin
      capacity <= 32'hFFFF_FFFF;
      clear_stream();
      expected_bytes.delete();
    end else begin
      if (m_tvalid && m_tready) compare_result();
      if (cfg_valid && cfg_ready) capacity <= cfg_data;
      if (s_tvalid && s_tready) decode_byte(s_tdata, s_tlast);
    end
  end

endmodule

// ===== verif/tb.sv =====
// Stimulus and verdict for the raw-block decompressor core.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned CycleLimit = 4000000;
  localparam int unsigned DrainCycles = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic [4:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;
  int          pending;
  int          fail_count;

  bit          calm = 1'b0;
  bit          hold_request = 1'b0;
  bit          holding = 1'b0;
  int unsigned cycle_count = 0;

  logic [7:0]      stream_q[$];
  longint unsigned gen_written;

  always #4 clk = ~clk;

  snappy_raw_decompressor_core u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  snappy_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .pending(pending), .fail_count(fail_count)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(negedge clk)
    m_tready <= holding ? 1'b0 : (calm ? 1'b1 : ($urandom_range(99) >= 30));

  // The receiver stops for a long stretch while the sender keeps offering items.
  initial begin
    wait (hold_request);
    @(negedge clk);
    holding = 1'b1;
    repeat (400) @(posedge clk);
    @(negedge clk);
    holding = 1'b0;
  end

  task automatic send_item(input logic [7:0] b, input logic last);
    @(negedge clk);
    if (!calm)
      while ($urandom_range(99) < 30) begin
        s_tvalid = 1'b0;
        @(negedge clk);
      end
    s_tvalid = 1'b1;
    s_tdata = b;
    s_tlast = last;
    #1;
    while (!s_tready) begin
      @(negedge clk);
      #1;
    end
    @(posedge clk);
  endtask

  task automatic send_stream();
    foreach (stream_q[i]) send_item(stream_q[i], i == stream_q.size() - 1);
    @(negedge clk);
    s_tvalid = 1'b0;
    s_tlast = 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [31:0] value);
    wait_idle();
    cfg_valid = 1'b1;
    cfg_data = value;
    #1;
    while (!cfg_ready) begin
      @(negedge clk);
      #1;
    end
    @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic put_varint(input longint unsigned v);
    while (v >= 128) begin
      stream_q.push_back(8'h80 | v[6:0]);
      v = v >> 7;
    end
    stream_q.push_back(v[7:0]);
  endtask

  // Literal of len bytes; long forms use nlen length bytes (0 for the short tag).
  task automatic put_literal(input int unsigned len, input int unsigned nlen);
    longint unsigned lm1;
    lm1 = len - 1;
    if (nlen == 0) stream_q.push_back(8'((len - 1) << 2));
    else begin
      stream_q.push_back(8'((59 + nlen) << 2));
      for (int i = 0; i < nlen; i++) stream_q.push_back(8'(lm1 >> (8 * i)));
    end
    repeat (len) stream_q.push_back(8'($urandom));
    gen_written += len;
  endtask

  task automatic put_copy(input int unsigned kind, input int unsigned len,
                          input longint unsigned ofs);
    if (kind == 1) begin
      stream_q.push_back({3'(ofs >> 8), 3'(len - 4), 2'd1});
      stream_q.push_back(8'(ofs));
    end else begin
      stream_q.push_back({6'(len - 1), 2'(kind)});
      for (int i = 0; i < ((kind == 2) ? 2 : 4); i++) stream_q.push_back(8'(ofs >> (8 * i)));
    end
    gen_written += len;
  endtask

  // A well-formed stream with random tags and content.
  task automatic build_valid_stream(input int unsigned decl);
    int unsigned left, len, kind;
    stream_q.delete();
    gen_written = 0;
    put_varint(decl);
    while (gen_written < decl) begin
      left = decl - 32'(gen_written);
      if (gen_written == 0 || $urandom_range(2) == 0) begin
        len = $urandom_range((left > 12) ? 12 : left, 1);
        put_literal(len, ($urandom_range(3) == 0) ? $urandom_range(4, 1) : 0);
      end else begin
        kind = $urandom_range(3, 1);
        if (kind == 1 && left < 4) kind = 2;
        len = (kind == 1) ? $urandom_range((left > 11) ? 11 : left, 4)
                          : $urandom_range((left > 64) ? 64 : left, 1);
        put_copy(kind, len, $urandom_range((gen_written > 2047) ? 2047 : 32'(gen_written), 1));
      end
    end
  endtask

  task automatic run_directed();
    // Empty stream, then a stream ending inside the header.
    stream_q = '{8'h00};
    send_stream();
    stream_q = '{8'h85};
    send_stream();
    // Continuation on the fifth header byte, and a header above 32 bits.
    stream_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h11};
    send_stream();
    stream_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h00};
    send_stream();
    // Largest 32-bit header, then the stream ends between tags.
    stream_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0F, 8'h00, 8'hAA};
    send_stream();
    // Overlapping copies of every kind; each byte value extreme in the data.
    stream_q.delete();
    gen_written = 0;
    put_varint(90);
    stream_q.push_back(8'h04);
    stream_q.push_back(8'h00);
    stream_q.push_back(8'hFF);
    gen_written = 2;
    put_copy(1, 11, 1);
    put_copy(2, 64, 2);
    put_copy(3, 13, 7);
    send_stream();
    // Offset zero, offset past the written bytes, and an overrunning copy.
    stream_q = '{8'h0A, 8'h04, 8'h11, 8'h22, 8'h01, 8'h00, 8'h33};
    send_stream();
    stream_q = '{8'h0A, 8'h04, 8'h11, 8'h22, 8'h02, 8'h03, 8'h00};
    send_stream();
    stream_q = '{8'h04, 8'h04, 8'h11, 8'h22, 8'hFE, 8'h01, 8'h00};
    send_stream();
    // Overrunning literal, and streams cut after a literal length, inside data and offset.
    stream_q = '{8'h02, 8'h08, 8'h01, 8'h02, 8'h03};
    send_stream();
    stream_q = '{8'h10, 8'hF0, 8'h05};
    send_stream();
    stream_q = '{8'h10, 8'h0C, 8'h05};
    send_stream();
    stream_q = '{8'h10, 8'h00, 8'h05, 8'h0E, 8'h01};
    send_stream();
  endtask

  task automatic run_random(input int unsigned items);
    int unsigned sent, pick, cut;
    sent = 0;
    while (sent < items) begin
      pick = $urandom_range(99);
      build_valid_stream($urandom_range(99) < 10 ? $urandom_range(200, 100)
                                                  : $urandom_range(30));
      if (pick >= 90) begin
        stream_q.delete();
        repeat ($urandom_range(8, 1)) stream_q.push_back(8'($urandom));
      end else if (pick >= 80) begin
        cut = $urandom_range(stream_q.size() - 1, 1);
        while (stream_q.size() > cut) void'(stream_q.pop_back());
      end else if (pick >= 72) begin
        stream_q[$urandom_range(stream_q.size() - 1)] = 8'($urandom);
      end
      sent += stream_q.size();
      send_stream();
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst = 1'b0;
    run_directed();
    write_capacity(32'd5);
    stream_q = '{8'h06, 8'h14, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06};
    send_stream();
    build_valid_stream(5);
    send_stream();
    write_capacity(32'd0);
    stream_q = '{8'h00};
    send_stream();
    stream_q = '{8'h01, 8'h00, 8'h42};
    send_stream();
    write_capacity(32'hFFFF_FFFF);
    wait_idle();
    hold_request = 1'b1;
    run_random(30);
    write_capacity($urandom_range(40, 10));
    calm = 1'b1;
    run_random(30);
    calm = 1'b0;
    write_capacity(32'hFFFF_FFFF);
    run_random(30);
    wait_idle();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/snappy_pkg.sv
hw/rtl/snappy_ram.sv
hw/rtl/snappy_raw_decompressor_core.sv
verif/snappy_checker.sv
verif/tb.sv
